### src/assert_macros.svh
// Assertion macros used by the neighbor table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define NT_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ntwqr assertion failed");

// Condition must never be true outside reset.
`define NT_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ntwqr forbidden condition seen");

`else

`define NT_ASSERT(name, clk, rst_n, prop)
`define NT_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

### src/ntwqr_pkg.sv
// Package: sizes, request and status codes, and sequencer states of the neighbor table.
`timescale 1ns / 1ps

package ntwqr_pkg;

  localparam int MAX_ENTRIES = 4;

  localparam int ADDR_W   = 16;
  localparam int QUAL_W   = 16;
  localparam int REQ_W    = 2;
  localparam int SLOT_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 3;

  localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int ENTRY_W = ADDR_W + QUAL_W;
  localparam int WIDE_W  = CNT_W + SLOT_W;

  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_MISS = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RM_RD,
    S_RM_WR,
    S_RESP
  } nt_state_e;

endpackage

### src/ntwqr_if.sv
// Request and response channel interfaces of the neighbor table.
`timescale 1ns / 1ps

interface ntwqr_req_if import ntwqr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [ADDR_W-1:0] peer_address;
  logic [QUAL_W-1:0] link_quality;
  logic [SLOT_W-1:0] slot_index;

  modport source (output valid, req_type, peer_address, link_quality, slot_index,
                  input ready);
  modport sink   (input valid, req_type, peer_address, link_quality, slot_index,
                  output ready);
endinterface

interface ntwqr_rsp_if import ntwqr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   result_slot;
  logic                evicted;
  logic [ADDR_W-1:0]   evicted_address;
  logic [QUAL_W-1:0]   found_quality;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, result_slot, evicted, evicted_address,
                  found_quality, entry_count, input ready);
  modport sink   (input valid, status, result_slot, evicted, evicted_address,
                  found_quality, entry_count, output ready);
endinterface

### src/neighbor_table_worst_quality_replace.sv
// Top level: packed neighbor table with lowest-quality eviction.
//
//   channel  | dir | transaction carries
//   ---------+-----+------------------------------------------------------------
//   req_i    | in  | req_type, peer_address, link_quality, slot_index
//   rsp_o    | out | status, result_slot, evicted, evicted_address,
//            |     | found_quality, entry_count
//
// One request at a time. Add and search scan the valid slots through the entry
// RAM (one read per cycle, registered read data) until a hit; an add that misses
// fills a free slot or evicts the lowest-quality one. Remove moves the last entry
// into the freed slot; a rejected request goes straight to the response state.
// Reset clears the control registers, not the RAM; RAM contents are never read
// beyond the count. A result waits in the output register; a stalled output
// holds the next result in the response state until the register frees up.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module neighbor_table_worst_quality_replace import ntwqr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  ntwqr_req_if.sink    req_i,
  ntwqr_rsp_if.source  rsp_o
);

  // Entry RAM: {address, quality}
  logic [ENTRY_W-1:0] mem_q [MAX_ENTRIES];
  logic [ENTRY_W-1:0] rdata_q;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               rd_en;
  logic [IDX_W-1:0]   raddr;

  nt_state_e state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  ptr_q, ptr_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]  worst_idx_q, worst_idx_d;
  logic [QUAL_W-1:0] worst_qual_q, worst_qual_d;
  logic [ADDR_W-1:0] worst_addr_q, worst_addr_d;

  logic [REQ_W-1:0]  rq_type_q, rq_type_d;
  logic [ADDR_W-1:0] rq_addr_q, rq_addr_d;
  logic [QUAL_W-1:0] rq_qual_q, rq_qual_d;
  logic [SLOT_W-1:0] rq_slot_q, rq_slot_d;

  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [IDX_W-1:0]    res_slot_q, res_slot_d;
  logic                res_ev_q, res_ev_d;
  logic [ADDR_W-1:0]   res_ev_addr_q, res_ev_addr_d;
  logic [QUAL_W-1:0]   res_fq_q, res_fq_d;

  logic                out_valid_q, out_valid_d;
  logic                out_load;
  logic [STATUS_W-1:0] out_status_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic                out_ev_q;
  logic [ADDR_W-1:0]   out_ev_addr_q;
  logic [QUAL_W-1:0]   out_fq_q;
  logic [COUNT_W-1:0]  out_count_q;

  logic [ADDR_W-1:0] rd_addr;
  logic [QUAL_W-1:0] rd_qual;
  logic              match;

  assign rd_addr = rdata_q[ENTRY_W-1 -: ADDR_W];
  assign rd_qual = rdata_q[QUAL_W-1:0];
  assign match   = pend_q && (rd_addr == rq_addr_q);

  assign req_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    ptr_d         = ptr_q;
    pend_d        = 1'b0;
    cmp_idx_d     = cmp_idx_q;
    worst_idx_d   = worst_idx_q;
    worst_qual_d  = worst_qual_q;
    worst_addr_d  = worst_addr_q;
    rq_type_d     = rq_type_q;
    rq_addr_d     = rq_addr_q;
    rq_qual_d     = rq_qual_q;
    rq_slot_d     = rq_slot_q;
    res_status_d  = res_status_q;
    res_slot_d    = res_slot_q;
    res_ev_d      = res_ev_q;
    res_ev_addr_d = res_ev_addr_q;
    res_fq_d      = res_fq_q;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    rd_en         = 1'b0;
    raddr         = '0;
    out_load      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          rq_type_d     = req_i.req_type;
          rq_addr_d     = req_i.peer_address;
          rq_qual_d     = req_i.link_quality;
          rq_slot_d     = req_i.slot_index;
          ptr_d         = '0;
          res_status_d  = STAT_DONE;
          res_slot_d    = '0;
          res_ev_d      = 1'b0;
          res_ev_addr_d = '0;
          res_fq_d      = '0;
          case (req_i.req_type)
            REQ_ADD, REQ_SEARCH: state_d = S_SCAN;
            REQ_REMOVE: begin
              if (WIDE_W'(req_i.slot_index) >= WIDE_W'(cnt_q)) begin
                res_status_d = STAT_BAD;
                state_d      = S_RESP;
              end else begin
                state_d = S_RM_RD;
              end
            end
            default: begin
              res_status_d = STAT_BAD;
              state_d      = S_RESP;
            end
          endcase
        end
      end

      S_SCAN: begin
        // keep the first lowest-quality slot seen
        if (pend_q && ((cmp_idx_q == '0) || (rd_qual < worst_qual_q))) begin
          worst_idx_d  = cmp_idx_q;
          worst_qual_d = rd_qual;
          worst_addr_d = rd_addr;
        end
        if (match) begin
          res_slot_d = cmp_idx_q;
          if (rq_type_q == REQ_ADD) begin
            res_status_d = STAT_DUP;
          end else begin
            res_fq_d = rd_qual;
          end
          state_d = S_RESP;
        end else if (ptr_q < cnt_q) begin
          rd_en     = 1'b1;
          raddr     = ptr_q[IDX_W-1:0];
          pend_d    = 1'b1;
          cmp_idx_d = ptr_q[IDX_W-1:0];
          ptr_d     = ptr_q + CNT_W'(1);
        end else if (!pend_q) begin
          // scan finished without a hit
          if (rq_type_q == REQ_SEARCH) begin
            res_status_d = STAT_MISS;
          end else if (cnt_q < CNT_W'(MAX_ENTRIES)) begin
            mem_we     = 1'b1;
            mem_waddr  = cnt_q[IDX_W-1:0];
            mem_wdata  = {rq_addr_q, rq_qual_q};
            res_slot_d = cnt_q[IDX_W-1:0];
            cnt_d      = cnt_q + CNT_W'(1);
          end else begin
            mem_we        = 1'b1;
            mem_waddr     = worst_idx_q;
            mem_wdata     = {rq_addr_q, rq_qual_q};
            res_slot_d    = worst_idx_q;
            res_ev_d      = 1'b1;
            res_ev_addr_d = worst_addr_q;
          end
          state_d = S_RESP;
        end
      end

      S_RM_RD: begin
        rd_en   = 1'b1;
        raddr   = IDX_W'(cnt_q - CNT_W'(1));
        state_d = S_RM_WR;
      end

      S_RM_WR: begin
        // last entry fills the freed slot
        mem_we    = 1'b1;
        mem_waddr = IDX_W'(rq_slot_q);
        mem_wdata = rdata_q;
        cnt_d     = cnt_q - CNT_W'(1);
        state_d   = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ptr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q     <= cmp_idx_d;
    worst_idx_q   <= worst_idx_d;
    worst_qual_q  <= worst_qual_d;
    worst_addr_q  <= worst_addr_d;
    rq_type_q     <= rq_type_d;
    rq_addr_q     <= rq_addr_d;
    rq_qual_q     <= rq_qual_d;
    rq_slot_q     <= rq_slot_d;
    res_status_q  <= res_status_d;
    res_slot_q    <= res_slot_d;
    res_ev_q      <= res_ev_d;
    res_ev_addr_q <= res_ev_addr_d;
    res_fq_q      <= res_fq_d;
    if (out_load) begin
      out_status_q  <= res_status_q;
      out_slot_q    <= SLOT_W'(res_slot_q);
      out_ev_q      <= res_ev_q;
      out_ev_addr_q <= res_ev_addr_q;
      out_fq_q      <= res_fq_q;
      out_count_q   <= COUNT_W'(cnt_q);
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.result_slot     = out_slot_q;
  assign rsp_o.evicted         = out_ev_q;
  assign rsp_o.evicted_address = out_ev_addr_q;
  assign rsp_o.found_quality   = out_fq_q;
  assign rsp_o.entry_count     = out_count_q;

  `NT_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q <= CNT_W'(MAX_ENTRIES))
  `NT_ASSERT(a_accept_leaves_idle, clk_i, rst_ni,
             (req_i.valid && req_i.ready) |=> (state_q != S_IDLE))
  `NT_ASSERT(a_cnt_step, clk_i, rst_ni,
             (cnt_q != $past(cnt_q)) |-> ((cnt_q == $past(cnt_q) + CNT_W'(1)) ||
                                          (cnt_q + CNT_W'(1) == $past(cnt_q))))
  `NT_ASSERT_NEVER(a_no_write_idle, clk_i, rst_ni, mem_we && (state_q == S_IDLE))

endmodule

### tb/sv/tb_top.sv
// Testbench for the neighbor table: directed and random requests checked against a table model.
`timescale 1ns / 1ps

module tb_top;
  import ntwqr_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 20;
  localparam int POOL_SIZE       = 8;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   result_slot;
    logic                evicted;
    logic [ADDR_W-1:0]   evicted_address;
    logic [QUAL_W-1:0]   found_quality;
    logic [COUNT_W-1:0]  entry_count;
  } table_rsp_t;

  logic clk;
  logic rst_n;

  ntwqr_req_if req_if ();
  ntwqr_rsp_if rsp_if ();

  neighbor_table_worst_quality_replace u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Model of the table contents, updated on every accepted request
  logic [ADDR_W-1:0] peer_addr_q [MAX_ENTRIES];
  logic [QUAL_W-1:0] peer_qual_q [MAX_ENTRIES];
  int                peer_count = 0;

  table_rsp_t pending_responses [$];
  int         error_count    = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  int         hold_off_asked = 0;
  int         hold_off_taken = 0;
  int         hold_off_left  = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic table_rsp_t predict_table_response(
      logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr,
      logic [QUAL_W-1:0] qual, logic [SLOT_W-1:0] slot);
    table_rsp_t rsp;
    int         hit;
    int         worst;
    int         last;
    rsp   = '0;
    hit   = -1;
    worst = 0;
    // scan downward so the lowest matching slot wins
    for (int i = peer_count - 1; i >= 0; i--) begin
      if (peer_addr_q[i] == addr) hit = i;
    end
    case (kind)
      REQ_ADD: begin
        if (hit >= 0) begin
          rsp.status      = STAT_DUP;
          rsp.result_slot = hit[SLOT_W-1:0];
        end else if (peer_count < MAX_ENTRIES) begin
          peer_addr_q[peer_count] = addr;
          peer_qual_q[peer_count] = qual;
          rsp.result_slot         = peer_count[SLOT_W-1:0];
          peer_count++;
        end else begin
          // strict less-than: first slot wins on a tie
          for (int i = 1; i < MAX_ENTRIES; i++) begin
            if (peer_qual_q[i] < peer_qual_q[worst]) worst = i;
          end
          rsp.evicted         = 1'b1;
          rsp.evicted_address = peer_addr_q[worst];
          peer_addr_q[worst]  = addr;
          peer_qual_q[worst]  = qual;
          rsp.result_slot     = worst[SLOT_W-1:0];
        end
      end
      REQ_REMOVE: begin
        if (int'(slot) >= peer_count) begin
          rsp.status = STAT_BAD;
        end else begin
          last              = peer_count - 1;
          peer_addr_q[slot] = peer_addr_q[last];
          peer_qual_q[slot] = peer_qual_q[last];
          peer_count        = last;
        end
      end
      REQ_SEARCH: begin
        if (hit >= 0) begin
          rsp.result_slot   = hit[SLOT_W-1:0];
          rsp.found_quality = peer_qual_q[hit];
        end else begin
          rsp.status = STAT_MISS;
        end
      end
      default: begin
        rsp.status = STAT_BAD;
      end
    endcase
    rsp.entry_count = peer_count[COUNT_W-1:0];
    return rsp;
  endfunction

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      error_count++;
    end
  endfunction

  // Response check first, then prediction of the request accepted at this edge
  always @(posedge clk) begin : monitor
    table_rsp_t got;
    table_rsp_t want;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = {rsp_if.status, rsp_if.result_slot, rsp_if.evicted, rsp_if.evicted_address,
               rsp_if.found_quality, rsp_if.entry_count};
        if (pending_responses.size() == 0) begin
          $error("response transaction with nothing expected: 0x%0h", got);
          error_count++;
        end else begin
          want = pending_responses.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("result_slot", 32'(want.result_slot), 32'(got.result_slot));
          check_field("evicted", 32'(want.evicted), 32'(got.evicted));
          check_field("evicted_address", 32'(want.evicted_address),
                      32'(got.evicted_address));
          check_field("found_quality", 32'(want.found_quality), 32'(got.found_quality));
          check_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
        end
      end
      if (req_if.valid && req_if.ready) begin
        pending_responses = {pending_responses, predict_table_response(req_if.req_type,
            req_if.peer_address, req_if.link_quality, req_if.slot_index)};
      end
    end
  end

  // Response side: random stalls, plus a long hold-off when a test asks for one
  always @(posedge clk) begin
    if (hold_off_taken != hold_off_asked) begin
      hold_off_taken <= hold_off_asked;
      hold_off_left  <= HOLD_OFF_CYCLES;
      rsp_if.ready   <= 1'b0;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
      rsp_if.ready  <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Called right after a rising edge; returns at the edge that takes the transaction
  task automatic send_request(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr,
                              logic [QUAL_W-1:0] qual, logic [SLOT_W-1:0] slot);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.req_type     <= kind;
    req_if.peer_address <= addr;
    req_if.link_quality <= qual;
    req_if.slot_index   <= slot;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_request(REQ_SEARCH, 16'h0000, 16'hFFFF, 2'd0);
    send_request(REQ_REMOVE, 16'hFFFF, 16'h0000, 2'd0);
    send_request(REQ_REMOVE, 16'h0000, 16'h0000, 2'd3);
    send_request(REQ_UNKNOWN, 16'hFFFF, 16'hFFFF, 2'd3);
  endtask

  task automatic test_fill_and_evict();
    send_request(REQ_ADD, 16'h0000, 16'hFFFF, 2'd3);
    send_request(REQ_ADD, 16'hFFFF, 16'h0000, 2'd0);
    send_request(REQ_ADD, 16'h1234, 16'h8000, 2'd0);
    send_request(REQ_ADD, 16'hFFFF, 16'h1111, 2'd0);   // duplicate
    send_request(REQ_SEARCH, 16'hFFFF, 16'h0000, 2'd0);
    send_request(REQ_ADD, 16'hABCD, 16'h8000, 2'd0);   // table now full
    send_request(REQ_ADD, 16'h5555, 16'h0001, 2'd0);   // evicts quality zero
    send_request(REQ_ADD, 16'h7777, 16'h8000, 2'd0);
    send_request(REQ_ADD, 16'h6666, 16'h0005, 2'd0);   // three-way tie, first slot goes
    send_request(REQ_SEARCH, 16'h6666, 16'h0000, 2'd0);
    send_request(REQ_UNKNOWN, 16'h0000, 16'h0000, 2'd0);
    send_request(REQ_ADD, 16'h0000, 16'h0000, 2'd0);   // duplicate while full
  endtask

  task automatic test_remove();
    send_request(REQ_REMOVE, 16'h0000, 16'h0000, 2'd3);
    send_request(REQ_REMOVE, 16'h0000, 16'h0000, 2'd3); // at the count
    send_request(REQ_REMOVE, 16'h0000, 16'h0000, 2'd0); // last entry moves down
    send_request(REQ_SEARCH, 16'h0000, 16'h0000, 2'd0);
    send_request(REQ_REMOVE, 16'h0000, 16'h0000, 2'd1);
    send_request(REQ_REMOVE, 16'h0000, 16'h0000, 2'd0);
    send_request(REQ_REMOVE, 16'h0000, 16'h0000, 2'd0);
  endtask

  task automatic test_random(int items, int send_pct, int recv_pct);
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
    logic [REQ_W-1:0]  kind;
    logic [ADDR_W-1:0] addr;
    logic [QUAL_W-1:0] qual;
    int                pick;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    foreach (addr_pool[i]) addr_pool[i] = ADDR_W'($urandom());
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) kind = REQ_ADD;
      else if (pick < 65) kind = REQ_REMOVE;
      else if (pick < 95) kind = REQ_SEARCH;
      else kind = REQ_UNKNOWN;
      // a small address pool keeps hits, duplicates and full-table evictions frequent
      addr = ($urandom_range(9) < 7) ? addr_pool[$urandom_range(POOL_SIZE - 1)]
                                     : ADDR_W'($urandom());
      // few distinct scores give ties in the eviction scan
      qual = ($urandom_range(3) == 0) ? QUAL_W'($urandom_range(3)) : QUAL_W'($urandom());
      send_request(kind, addr, qual, SLOT_W'($urandom_range(3)));
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_asked++;
    for (int n = 0; n < 30; n++) begin
      send_request(REQ_W'($urandom_range(2)), ADDR_W'($urandom_range(7)),
                   QUAL_W'($urandom()), SLOT_W'($urandom_range(3)));
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.req_type     = REQ_ADD;
    req_if.peer_address = '0;
    req_if.link_quality = '0;
    req_if.slot_index   = '0;
    rsp_if.ready        = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_fill_and_evict();
    test_remove();
    test_random(500, 0, 0);
    test_random(500, 70, 0);
    test_random(500, 0, 70);
    test_random(500, 21, 21);
    test_backpressure();
    test_random(50, 21, 21);
    req_if.valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
